>>> rtl/jsu_pkg.sv
// Shared types, character codes, status codes and helpers for the JSON string unescaper.
package jsu_pkg;

  localparam int MaxResults = 6;
  localparam int CntW       = $clog2(MaxResults + 1);

  // Status codes carried on the last result of an item.
  localparam logic [2:0] StOngoing      = 3'd0;
  localparam logic [2:0] StDone         = 3'd1;
  localparam logic [2:0] StUntermString = 3'd2;
  localparam logic [2:0] StUntermEscape = 3'd3;
  localparam logic [2:0] StTruncUnicode = 3'd4;
  localparam logic [2:0] StBadHex       = 3'd5;
  localparam logic [2:0] StControlChar  = 3'd6;
  localparam logic [2:0] StUnknownEsc   = 3'd7;

  // Characters with a special meaning in a string body.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChSpace     = 8'h20;

  localparam logic [15:0] HighSurrLo = 16'hd800;
  localparam logic [15:0] HighSurrHi = 16'hdbff;
  localparam logic [15:0] LowSurrLo  = 16'hdc00;
  localparam logic [15:0] LowSurrHi  = 16'hdfff;
  localparam logic [20:0] SuppBase   = 21'h10000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp < 21'h80) begin
      u.bytes[0] = cp[7:0];
      u.len      = 3'd1;
    end else if (cp < 21'h800) begin
      u.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
      u.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      u.len      = 3'd2;
    end else if (cp < SuppBase) begin
      u.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
      u.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      u.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      u.len      = 3'd3;
    end else begin
      u.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
      u.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      u.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      u.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      u.len      = 3'd4;
    end
    return u;
  endfunction

endpackage

>>> rtl/jsu_if.sv
// Valid/ready channels for raw string bytes and for decoded result items.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last,
                input status, output ready);
endinterface

>>> rtl/json_string_unescape_utf8_top.sv
// JSON string body unescaper: raw string bytes in, UTF-8 bytes and status out.
//
// in_i carries one raw byte of a string body per item (or an end-of-input
// marker); out_o carries result items, from one to six per input item, the
// final one flagged by last. Status is nonzero only on that final result:
// done at the closing quote, or an error code, after which decoding restarts
// in the plain body.
// An accepted item lands in an input register. When the result buffer is
// empty, or its final result leaves in that cycle, the item is decoded in one
// pass and its whole burst of results is written into a six-entry buffer whose
// head is shown on out_o. The output port drains one result per cycle while
// out_o.ready is high; items yielding one result flow at one item per cycle
// while out_o does not stall.
// While out_o is stalled, one further item is taken into the input register
// and then in_i.ready drops until the buffer can take that item's results.
// Reset empties both registers and returns the decoder to the plain body.
module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  typedef enum logic [2:0] {
    PhBody,
    PhEsc,
    PhHex1,
    PhHigh,
    PhHighBs,
    PhHex2
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [15:0]          acc_q, acc_d;
  logic [1:0]           seen_q, seen_d;
  logic [15:0]          held_q, held_d;
  logic                 in_full_q, in_full_d;
  logic [7:0]           in_byte_q, in_byte_d;
  logic                 in_eoi_q, in_eoi_d;
  res_t [MaxResults-1:0] buf_q, buf_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic        load;
  logic        pop;
  logic        a_en, b_en, tail_en, tail_use, clear;
  logic [20:0] a_cp, b_cp;
  res_t        tail;
  utf8_t       enc_a, enc_b;
  hex_t        hex;
  logic [15:0] acc_new;
  logic [2:0]  len_a, len_b;
  logic [2:0]  burst_len;
  res_t [MaxResults-1:0] burst;

  assign pop  = (cnt_q != '0) && out_o.ready;
  assign load = in_full_q && ((cnt_q == '0) || ((cnt_q == CntW'(1)) && out_o.ready));
  assign in_i.ready = !in_full_q || load;

  assign hex     = hex_digit(in_byte_q);
  assign acc_new = {acc_q[11:0], hex.value};

  // Decode of the held item against the current state.
  always_comb begin
    logic body_go;
    logic esc_go;
    body_go  = 1'b0;
    esc_go   = 1'b0;
    phase_d  = phase_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    held_d   = held_q;
    a_en     = 1'b0;
    a_cp     = '0;
    b_en     = 1'b0;
    b_cp     = '0;
    tail_en  = 1'b0;
    tail     = '0;
    clear    = 1'b0;
    if (in_eoi_q) begin
      clear   = 1'b1;
      tail_en = 1'b1;
      unique case (phase_q)
        PhEsc:          tail.status = StUntermEscape;
        PhHex1, PhHex2: tail.status = StTruncUnicode;
        PhHigh: begin
          a_en        = 1'b1;
          a_cp        = {5'b0, held_q};
          tail.status = StUntermString;
        end
        PhHighBs: begin
          a_en        = 1'b1;
          a_cp        = {5'b0, held_q};
          tail.status = StUntermEscape;
        end
        default:        tail.status = StUntermString;
      endcase
    end else begin
      unique case (phase_q)
        PhEsc: esc_go = 1'b1;
        PhHex1, PhHex2: begin
          if (!hex.ok) begin
            tail_en     = 1'b1;
            tail.status = StBadHex;
            clear       = 1'b1;
          end else if (seen_q != 2'd3) begin
            acc_d  = acc_new;
            seen_d = seen_q + 2'd1;
          end else begin
            acc_d  = '0;
            seen_d = '0;
            if (phase_q == PhHex1) begin
              if (acc_new >= HighSurrLo && acc_new <= HighSurrHi) begin
                held_d  = acc_new;
                phase_d = PhHigh;
              end else begin
                a_en    = 1'b1;
                a_cp    = {5'b0, acc_new};
                phase_d = PhBody;
              end
            end else begin
              a_en = 1'b1;
              if (acc_new >= LowSurrLo && acc_new <= LowSurrHi) begin
                a_cp = SuppBase + {1'b0, held_q[9:0], acc_new[9:0]};
              end else begin
                a_cp = {5'b0, held_q};
                b_en = 1'b1;
                b_cp = {5'b0, acc_new};
              end
              held_d  = '0;
              phase_d = PhBody;
            end
          end
        end
        PhHigh: begin
          if (in_byte_q == ChBackslash) begin
            phase_d = PhHighBs;
          end else begin
            a_en    = 1'b1;
            a_cp    = {5'b0, held_q};
            held_d  = '0;
            body_go = 1'b1;
          end
        end
        PhHighBs: begin
          if (in_byte_q == ChLowerU) begin
            phase_d = PhHex2;
            acc_d   = '0;
            seen_d  = '0;
          end else begin
            a_en   = 1'b1;
            a_cp   = {5'b0, held_q};
            held_d = '0;
            esc_go = 1'b1;
          end
        end
        default: body_go = 1'b1;
      endcase

      if (body_go) begin
        phase_d = PhBody;
        if (in_byte_q == ChQuote) begin
          tail_en     = 1'b1;
          tail.status = StDone;
          clear       = 1'b1;
        end else if (in_byte_q == ChBackslash) begin
          phase_d = PhEsc;
        end else if (in_byte_q < ChSpace) begin
          tail_en     = 1'b1;
          tail.status = StControlChar;
          clear       = 1'b1;
        end else begin
          tail_en         = 1'b1;
          tail.out_byte   = in_byte_q;
          tail.byte_valid = 1'b1;
        end
      end

      if (esc_go) begin
        phase_d         = PhBody;
        tail_en         = 1'b1;
        tail.byte_valid = 1'b1;
        case (in_byte_q)
          ChQuote, ChBackslash, ChSlash: tail.out_byte = in_byte_q;
          ChLowerB: tail.out_byte = 8'h08;
          ChLowerF: tail.out_byte = 8'h0c;
          ChLowerN: tail.out_byte = 8'h0a;
          ChLowerR: tail.out_byte = 8'h0d;
          ChLowerT: tail.out_byte = 8'h09;
          ChLowerU: begin
            tail_en         = 1'b0;
            tail.byte_valid = 1'b0;
            phase_d         = PhHex1;
            acc_d           = '0;
            seen_d          = '0;
          end
          default: begin
            tail.byte_valid = 1'b0;
            tail.status     = StUnknownEsc;
            clear           = 1'b1;
          end
        endcase
      end
    end

    if (clear) begin
      phase_d = PhBody;
      acc_d   = '0;
      seen_d  = '0;
      held_d  = '0;
    end
  end

  assign enc_a = utf8_encode(a_cp);
  assign enc_b = utf8_encode(b_cp);

  // Pack the first code point, the second one and the tail entry in order.
  always_comb begin
    logic [2:0] pos;
    logic [2:0] offs;
    pos       = '0;
    offs      = '0;
    len_a     = a_en ? enc_a.len : 3'd0;
    len_b     = b_en ? enc_b.len : 3'd0;
    // An item that yields nothing else still reports one empty result.
    tail_use  = tail_en || (!a_en && !b_en);
    burst_len = len_a + len_b + {2'b00, tail_use};
    for (int i = 0; i < MaxResults; i++) begin
      pos  = 3'(i);
      offs = pos - len_a;
      if (pos < len_a) begin
        burst[i] = '{out_byte: enc_a.bytes[pos[1:0]], byte_valid: 1'b1, status: StOngoing};
      end else if (offs < len_b) begin
        burst[i] = '{out_byte: enc_b.bytes[offs[1:0]], byte_valid: 1'b1, status: StOngoing};
      end else begin
        burst[i] = tail;
      end
    end
  end

  always_comb begin
    in_full_d = in_full_q;
    in_byte_d = in_byte_q;
    in_eoi_d  = in_eoi_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    if (load) begin
      in_full_d = 1'b0;
    end
    if (in_i.valid && in_i.ready) begin
      in_full_d = 1'b1;
      in_byte_d = in_i.in_byte;
      in_eoi_d  = in_i.end_of_input;
    end
    if (load) begin
      buf_d = burst;
      cnt_d = CntW'(burst_len);
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhBody;
      acc_q     <= '0;
      seen_q    <= '0;
      held_q    <= '0;
      in_full_q <= 1'b0;
      in_byte_q <= '0;
      in_eoi_q  <= 1'b0;
      buf_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (load) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        held_q  <= held_d;
      end
      in_full_q <= in_full_d;
      in_byte_q <= in_byte_d;
      in_eoi_q  <= in_eoi_d;
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = buf_q[0].out_byte;
  assign out_o.byte_valid = buf_q[0].byte_valid;
  assign out_o.status     = buf_q[0].status;
  assign out_o.last       = (cnt_q == CntW'(1));

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("result count exceeds buffer depth");

  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (out_o.status == StOngoing))
    else $error("nonzero status on a result that is not the last");

  a_status_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != StOngoing) |-> !out_o.byte_valid)
    else $error("done or error result carries a byte");

  a_held_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != '0) |-> (phase_q == PhHigh || phase_q == PhHighBs || phase_q == PhHex2))
    else $error("high surrogate held outside a pairing phase");

  a_load_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_o.valid)
    else $error("decoded item produced no result");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb;
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PhBody, PhEsc, PhHex1, PhHigh, PhHighBs, PhHex2
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [2:0] status;
  } utf8_res_t;

  class unescape_scoreboard;
    utf8_res_t  utf8_expected_q[$];
    utf8_res_t  burst_q[$];
    dec_phase_e phase;
    logic [15:0] hex_accum;
    logic [1:0]  digits_seen;
    logic [15:0] held_high;
    int          errors;

    function new();
      errors = 0;
      clear_decoder();
    endfunction

    function void clear_decoder();
      phase       = PhBody;
      hex_accum   = '0;
      digits_seen = '0;
      held_high   = '0;
    endfunction

    function void emit(logic [7:0] b, logic v, logic [2:0] st);
      utf8_res_t r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.last       = 1'b0;
      r.status     = st;
      burst_q = {burst_q, r};
    endfunction

    function void fail_code(logic [2:0] st);
      emit(8'h00, 1'b0, st);
      clear_decoder();
    endfunction

    function void put_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        emit(cp[7:0], 1'b1, StOngoing);
      end else if (cp < 21'h800) begin
        emit(8'hc0 | 8'(cp >> 6), 1'b1, StOngoing);
        emit(8'h80 | 8'(cp & 21'h3f), 1'b1, StOngoing);
      end else if (cp < 21'h10000) begin
        emit(8'he0 | 8'(cp >> 12), 1'b1, StOngoing);
        emit(8'h80 | 8'((cp >> 6) & 21'h3f), 1'b1, StOngoing);
        emit(8'h80 | 8'(cp & 21'h3f), 1'b1, StOngoing);
      end else begin
        emit(8'hf0 | 8'((cp >> 18) & 21'h7), 1'b1, StOngoing);
        emit(8'h80 | 8'((cp >> 12) & 21'h3f), 1'b1, StOngoing);
        emit(8'h80 | 8'((cp >> 6) & 21'h3f), 1'b1, StOngoing);
        emit(8'h80 | 8'(cp & 21'h3f), 1'b1, StOngoing);
      end
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void body_byte(logic [7:0] c);
      if (c == ChQuote) begin
        emit(8'h00, 1'b0, StDone);
        clear_decoder();
      end else if (c == ChBackslash) begin
        phase = PhEsc;
      end else if (c < ChSpace) begin
        fail_code(StControlChar);
      end else begin
        emit(c, 1'b1, StOngoing);
      end
    endfunction

    function void esc_byte(logic [7:0] c);
      logic [7:0] v;
      phase = PhBody;
      case (c)
        ChQuote:     v = ChQuote;
        ChBackslash: v = ChBackslash;
        ChSlash:     v = ChSlash;
        ChLowerB:    v = 8'h08;
        ChLowerF:    v = 8'h0c;
        ChLowerN:    v = 8'h0a;
        ChLowerR:    v = 8'h0d;
        ChLowerT:    v = 8'h09;
        ChLowerU: begin
          phase       = PhHex1;
          hex_accum   = '0;
          digits_seen = '0;
          return;
        end
        default: begin
          fail_code(StUnknownEsc);
          return;
        end
      endcase
      emit(v, 1'b1, StOngoing);
    endfunction

    function void hex_byte(logic [7:0] c, bit second);
      int d;
      d = nibble_of(c);
      if (d < 0) begin
        fail_code(StBadHex);
        return;
      end
      hex_accum = {hex_accum[11:0], 4'(d)};
      if (digits_seen < 2'd3) begin
        digits_seen++;
        return;
      end
      digits_seen = '0;
      if (!second) begin
        if (hex_accum >= HighSurrLo && hex_accum <= HighSurrHi) begin
          held_high = hex_accum;
          phase     = PhHigh;
        end else begin
          put_code_point(21'(hex_accum));
          phase = PhBody;
        end
      end else begin
        if (hex_accum >= LowSurrLo && hex_accum <= LowSurrHi) begin
          put_code_point(SuppBase + (21'(held_high - HighSurrLo) << 10)
                         + 21'(hex_accum - LowSurrLo));
        end else begin
          put_code_point(21'(held_high));
          put_code_point(21'(hex_accum));
        end
        held_high = '0;
        phase     = PhBody;
      end
      hex_accum = '0;
    endfunction

    // Predicts the burst of results for one accepted raw item.
    function void note_raw_item(logic [7:0] c, logic eoi);
      burst_q.delete();
      if (eoi) begin
        case (phase)
          PhEsc:          fail_code(StUntermEscape);
          PhHex1, PhHex2: fail_code(StTruncUnicode);
          PhHigh: begin
            put_code_point(21'(held_high));
            fail_code(StUntermString);
          end
          PhHighBs: begin
            put_code_point(21'(held_high));
            fail_code(StUntermEscape);
          end
          default:        fail_code(StUntermString);
        endcase
      end else begin
        case (phase)
          PhEsc:  esc_byte(c);
          PhHex1: hex_byte(c, 1'b0);
          PhHex2: hex_byte(c, 1'b1);
          PhHigh: begin
            if (c == ChBackslash) begin
              phase = PhHighBs;
            end else begin
              put_code_point(21'(held_high));
              held_high = '0;
              phase     = PhBody;
              body_byte(c);
            end
          end
          PhHighBs: begin
            if (c == ChLowerU) begin
              phase       = PhHex2;
              hex_accum   = '0;
              digits_seen = '0;
            end else begin
              put_code_point(21'(held_high));
              held_high = '0;
              esc_byte(c);
            end
          end
          default: body_byte(c);
        endcase
      end
      if (burst_q.size() == 0) emit(8'h00, 1'b0, StOngoing);
      burst_q[burst_q.size() - 1].last = 1'b1;
      utf8_expected_q = {utf8_expected_q, burst_q};
    endfunction

    function void check_result(logic [7:0] b, logic v, logic l, logic [2:0] st);
      utf8_res_t e;
      if (utf8_expected_q.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d", b, st);
        errors++;
        return;
      end
      e = utf8_expected_q.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", e.out_byte, b);
        errors++;
      end
      if (v !== e.byte_valid) begin
        $error("byte_valid: expected %0d, actual %0d", e.byte_valid, v);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, l);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return utf8_expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  unescape_scoreboard sb = new();

  int send_idle_pct = 19;
  int recv_idle_pct = 77;
  int hold_cycles   = 0;
  int items_sent    = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_raw_item(in_ch.in_byte, in_ch.end_of_input);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_byte, out_ch.byte_valid, out_ch.last, out_ch.status);
      end
    end
  end

  // Receiver side; a long hold-off is counted down here.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  // Sends a backslash-u escape with the given number of digits of v.
  task automatic send_uesc(input logic [15:0] v, input int ndigits);
    send_item(ChBackslash, 1'b0);
    send_item(ChLowerU, 1'b0);
    for (int i = 0; i < ndigits; i++) send_item(hex_char(v[15 - 4*i -: 4]), 1'b0);
  endtask

  function automatic logic [15:0] rand_high_surr();
    return 16'($urandom_range(int'(HighSurrLo), int'(HighSurrHi)));
  endfunction

  function automatic logic [7:0] rand_simple_esc();
    logic [7:0] choices [8];
    choices = '{ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN, ChLowerR,
                ChLowerT};
    return choices[$urandom_range(7)];
  endfunction

  function automatic logic [15:0] rand_code_unit();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(8'h7f));
      1:       return 16'($urandom_range('h80, 'h7ff));
      2:       return 16'($urandom_range(LowSurrLo, LowSurrHi));
      default: return 16'($urandom);
    endcase
  endfunction

  // One random piece of a string body, mostly well formed.
  task automatic send_random_piece();
    int         kind;
    logic [7:0] c;
    logic [15:0] v;
    kind = $urandom_range(99);
    if (kind < 28) begin
      do c = 8'($urandom_range(8'h20, 8'hff)); while (c == ChQuote || c == ChBackslash);
      send_item(c, 1'b0);
    end else if (kind < 42) begin
      send_item(ChBackslash, 1'b0);
      send_item(rand_simple_esc(), 1'b0);
    end else if (kind < 56) begin
      send_uesc(rand_code_unit(), 4);
    end else if (kind < 66) begin
      send_uesc(rand_high_surr(), 4);
      send_uesc(16'($urandom_range(LowSurrLo, LowSurrHi)), 4);
    end else if (kind < 70) begin
      // High surrogate followed by an escape that does not pair with it.
      send_uesc(rand_high_surr(), 4);
      do v = rand_code_unit(); while (v >= LowSurrLo && v <= LowSurrHi);
      send_uesc(v, 4);
    end else if (kind < 75) begin
      send_uesc(rand_high_surr(), 4);
      if ($urandom_range(1)) begin
        send_item(ChBackslash, 1'b0);
        send_item($urandom_range(3) == 0 ? 8'($urandom) : rand_simple_esc(), 1'b0);
      end else begin
        send_item(8'($urandom), 1'b0);
      end
    end else if (kind < 83) begin
      send_item(ChQuote, 1'b0);
    end else if (kind < 86) begin
      send_item(8'($urandom_range(8'h1f)), 1'b0);
    end else if (kind < 89) begin
      send_item(ChBackslash, 1'b0);
      do c = 8'($urandom);
      while (c inside {ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN,
                       ChLowerR, ChLowerT, ChLowerU});
      send_item(c, 1'b0);
    end else if (kind < 92) begin
      if ($urandom_range(1)) send_uesc(16'($urandom), $urandom_range(3));
      else begin
        send_uesc(rand_high_surr(), 4);
        send_uesc(16'($urandom), $urandom_range(3));
      end
      do c = 8'($urandom);
      while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
      send_item(c, 1'b0);
    end else if (kind < 97) begin
      // End of input in each decoder phase.
      case ($urandom_range(5))
        0: ;
        1: send_item(ChBackslash, 1'b0);
        2: send_uesc(16'($urandom), $urandom_range(3));
        3: send_uesc(rand_high_surr(), 4);
        4: begin
          send_uesc(rand_high_surr(), 4);
          send_item(ChBackslash, 1'b0);
        end
        default: begin
          send_uesc(rand_high_surr(), 4);
          send_uesc(16'($urandom), $urandom_range(3));
        end
      endcase
      send_item(8'($urandom), 1'b1);
    end else begin
      send_item(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int first_random;
    in_ch.valid        <= 1'b0;
    in_ch.in_byte      <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ChSpace, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h1f, 1'b0);
    send_text("\\t");
    send_text("\\uD83D\\uDE00");
    send_text("\\udbff");
    send_item(8'h00, 1'b1);
    send_text("\\uAx");
    send_item(ChQuote, 1'b0);
    send_item(ChBackslash, 1'b0);
    send_item(8'hff, 1'b1);

    first_random = items_sent;
    while (items_sent < first_random + 63) send_random_piece();
    send_idle_pct = 77;
    recv_idle_pct = 19;
    while (items_sent < first_random + 126) send_random_piece();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The output stalls for a long stretch while input keeps coming.
    hold_cycles = 80;
    while (items_sent < first_random + 190) send_random_piece();
    in_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
